/* design/block_read_statistics_counters_macros.svh */
// Assertion macros for the block read statistics counters.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef BLOCK_READ_STATISTICS_COUNTERS_MACROS_SVH
`define BLOCK_READ_STATISTICS_COUNTERS_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define BRSC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("brsc check failed");

// Next-cycle implication, disabled while in reset
`define BRSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("brsc check failed");

`endif

/* design/brsc_pkg.sv */
// Shared types and constants for the block read statistics counters.
// No dependencies; used by brsc_update and the top level.
package brsc_pkg;

    localparam int NUM_COUNTERS      = 15;
    localparam int COUNTER_WIDTH_DEF = 64;
    localparam int CIDX_W            = 4;
    localparam int MODE_W            = 2;
    localparam int S_TDATA_W         = 552;
    localparam int M_TDATA_W         = 64;

    // Record modes
    localparam logic [MODE_W-1:0] MODE_REC     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REC_DRV = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SNAP    = 2'd2;

    // Counter indexes
    localparam logic [CIDX_W-1:0] C_REQ         = 4'd0;
    localparam logic [CIDX_W-1:0] C_REQ_BYTES   = 4'd1;
    localparam logic [CIDX_W-1:0] C_SVC_MS      = 4'd2;
    localparam logic [CIDX_W-1:0] C_PEAK_MS     = 4'd3;
    localparam logic [CIDX_W-1:0] C_SEQ         = 4'd4;
    localparam logic [CIDX_W-1:0] C_DISC        = 4'd5;
    localparam logic [CIDX_W-1:0] C_OK          = 4'd6;
    localparam logic [CIDX_W-1:0] C_OK_BYTES    = 4'd7;
    localparam logic [CIDX_W-1:0] C_FAIL        = 4'd8;
    localparam logic [CIDX_W-1:0] C_DRV_CMD     = 4'd9;
    localparam logic [CIDX_W-1:0] C_DRV_SEC     = 4'd10;
    localparam logic [CIDX_W-1:0] C_DRV_BYTES   = 4'd11;
    localparam logic [CIDX_W-1:0] C_WITH_IO     = 4'd12;
    localparam logic [CIDX_W-1:0] C_NO_IO_REQ   = 4'd13;
    localparam logic [CIDX_W-1:0] C_NO_IO_BYTES = 4'd14;
    localparam logic [CIDX_W-1:0] C_LAST        = 4'd14;

    // One read record, as held in the input register
    typedef struct packed {
        logic [63:0] offset;
        logic [31:0] length;
        logic        seq_track;
        logic        succeeded;
        logic [63:0] before_commands;
        logic [63:0] before_sectors;
        logic [63:0] before_bytes;
        logic [63:0] after_commands;
        logic [63:0] after_sectors;
        logic [63:0] after_bytes;
        logic [63:0] service_ms;
    } rec_t;

    // Sequence tracking state
    typedef struct packed {
        logic [63:0] prev_end;
        logic        prev_valid;
    } seq_state_t;

endpackage

/* design/brsc_update.sv */
// Next-value logic for the fifteen saturating counters and sequence state.
// Depends on brsc_pkg.
module brsc_update #(
    parameter int COUNTER_WIDTH = brsc_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                          enable,
    input  logic [brsc_pkg::MODE_W-1:0]   mode,
    input  brsc_pkg::rec_t                rec,
    input  brsc_pkg::seq_state_t          seq_cur,
    input  logic [COUNTER_WIDTH-1:0]      cnt_cur  [brsc_pkg::NUM_COUNTERS],
    output brsc_pkg::seq_state_t          seq_next,
    output logic [COUNTER_WIDTH-1:0]      cnt_next [brsc_pkg::NUM_COUNTERS]
);
    import brsc_pkg::*;

    localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;
    localparam logic [64:0] CNT_MAX_X = {{(65-COUNTER_WIDTH){1'b0}}, CNT_MAX};

    // Add and clamp at the counter maximum
    function automatic logic [COUNTER_WIDTH-1:0] sat_add(
        input logic [COUNTER_WIDTH-1:0] cur,
        input logic [63:0]              amt
    );
        logic [64:0] sum;
        sum = {{(65-COUNTER_WIDTH){1'b0}}, cur} + {1'b0, amt};
        if (sum > CNT_MAX_X)
            return CNT_MAX;
        return sum[COUNTER_WIDTH-1:0];
    endfunction

    logic [63:0]              len_x;
    logic [COUNTER_WIDTH-1:0] peak_cand;
    logic                     drv_ok;
    logic [63:0]              dcmd;
    logic [63:0]              dsec;
    logic [63:0]              dbytes;

    assign len_x  = {32'd0, rec.length};
    assign dcmd   = rec.after_commands - rec.before_commands;
    assign dsec   = rec.after_sectors - rec.before_sectors;
    assign dbytes = rec.after_bytes - rec.before_bytes;

    // Clamp the service time to the counter range for the peak
    assign peak_cand = ({1'b0, rec.service_ms} > CNT_MAX_X) ? CNT_MAX
                     : rec.service_ms[COUNTER_WIDTH-1:0];

    // Drive stats count only when no total ran backwards
    assign drv_ok = (mode == MODE_REC_DRV)
                 && (rec.after_commands >= rec.before_commands)
                 && (rec.after_sectors >= rec.before_sectors)
                 && (rec.after_bytes >= rec.before_bytes);

    // Compute every counter update in parallel
    always_comb
    begin
        cnt_next = cnt_cur;
        seq_next = seq_cur;
        if (enable && (mode == MODE_REC || mode == MODE_REC_DRV))
        begin
            cnt_next[C_REQ]       = sat_add(cnt_cur[C_REQ], 64'd1);
            cnt_next[C_REQ_BYTES] = sat_add(cnt_cur[C_REQ_BYTES], len_x);
            cnt_next[C_SVC_MS]    = sat_add(cnt_cur[C_SVC_MS], rec.service_ms);
            if (peak_cand > cnt_cur[C_PEAK_MS])
                cnt_next[C_PEAK_MS] = peak_cand;

            if (rec.seq_track)
            begin
                if (seq_cur.prev_valid)
                begin
                    if (rec.offset == seq_cur.prev_end)
                        cnt_next[C_SEQ] = sat_add(cnt_cur[C_SEQ], 64'd1);
                    else
                        cnt_next[C_DISC] = sat_add(cnt_cur[C_DISC], 64'd1);
                end
                seq_next.prev_end   = rec.offset + len_x;
                seq_next.prev_valid = 1'b1;
            end

            if (rec.succeeded)
            begin
                cnt_next[C_OK]       = sat_add(cnt_cur[C_OK], 64'd1);
                cnt_next[C_OK_BYTES] = sat_add(cnt_cur[C_OK_BYTES], len_x);
            end
            else
            begin
                cnt_next[C_FAIL] = sat_add(cnt_cur[C_FAIL], 64'd1);
            end

            if (drv_ok)
            begin
                cnt_next[C_DRV_CMD]   = sat_add(cnt_cur[C_DRV_CMD], dcmd);
                cnt_next[C_DRV_SEC]   = sat_add(cnt_cur[C_DRV_SEC], dsec);
                cnt_next[C_DRV_BYTES] = sat_add(cnt_cur[C_DRV_BYTES], dbytes);
                if (dcmd != 64'd0)
                begin
                    cnt_next[C_WITH_IO] = sat_add(cnt_cur[C_WITH_IO], 64'd1);
                end
                else if (rec.succeeded)
                begin
                    cnt_next[C_NO_IO_REQ]   = sat_add(cnt_cur[C_NO_IO_REQ], 64'd1);
                    cnt_next[C_NO_IO_BYTES] = sat_add(cnt_cur[C_NO_IO_BYTES], len_x);
                end
            end
        end
    end

endmodule

/* design/block_read_statistics_counters.sv */
// Channel   Signals                         Word
// s         s_tvalid s_tready s_tdata s_tuser  one read record (tuser = mode)
// m         m_tvalid m_tready m_tdata m_tuser m_tlast  one counter (tuser = index)
//
// A record word is held in the input register, and all counters update together
// from it at the next edge. A snapshot word stays in the input register until all
// fifteen counter words are loaded, one counter word into the output register in
// each cycle that register is free; a stalled output holds only snapshots, never
// records.
// Reset clears all counters and the sequence tracking at once.
// Depends on brsc_pkg, brsc_update and the macros header.
`include "block_read_statistics_counters_macros.svh"

module block_read_statistics_counters #(
    parameter int COUNTER_WIDTH = brsc_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [63:0] offset, [95:64] length, [96] seq_track, [97] succeeded,
    // [161:98] before_commands, [225:162] before_sectors, [289:226] before_bytes,
    // [353:290] after_commands, [417:354] after_sectors, [481:418] after_bytes,
    // [545:482] service_ms, [551:546] zero
    input  logic [brsc_pkg::S_TDATA_W-1:0]    s_tdata,
    // [1:0] mode
    input  logic [brsc_pkg::MODE_W-1:0]       s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [63:0] counter_value
    output logic [brsc_pkg::M_TDATA_W-1:0]    m_tdata,
    // [3:0] counter_index
    output logic [brsc_pkg::CIDX_W-1:0]       m_tuser,
    // final_item
    output logic                              m_tlast
);
    import brsc_pkg::*;

    logic                     in_valid_reg;
    logic [MODE_W-1:0]        in_mode_reg;
    rec_t                     in_rec_reg;
    rec_t                     s_rec;
    logic [CIDX_W-1:0]        snap_idx_reg;
    logic [COUNTER_WIDTH-1:0] counters_reg [NUM_COUNTERS];
    logic [COUNTER_WIDTH-1:0] counters_next [NUM_COUNTERS];
    seq_state_t               seq_reg;
    seq_state_t               seq_next;
    logic                     m_valid_reg;
    logic [M_TDATA_W-1:0]     m_data_reg;
    logic [CIDX_W-1:0]        m_idx_reg;
    logic                     m_last_reg;
    logic                     is_snap;
    logic                     out_load;
    logic                     in_done;

    // Unpack the slave word
    assign s_rec.offset          = s_tdata[63:0];
    assign s_rec.length          = s_tdata[95:64];
    assign s_rec.seq_track       = s_tdata[96];
    assign s_rec.succeeded       = s_tdata[97];
    assign s_rec.before_commands = s_tdata[161:98];
    assign s_rec.before_sectors  = s_tdata[225:162];
    assign s_rec.before_bytes    = s_tdata[289:226];
    assign s_rec.after_commands  = s_tdata[353:290];
    assign s_rec.after_sectors   = s_tdata[417:354];
    assign s_rec.after_bytes     = s_tdata[481:418];
    assign s_rec.service_ms      = s_tdata[545:482];

    // Snapshot walks the counters as the output register frees up
    assign is_snap  = in_valid_reg && (in_mode_reg == MODE_SNAP);
    assign out_load = is_snap && (!m_valid_reg || m_tready);
    assign in_done  = in_valid_reg && (!is_snap || (out_load && snap_idx_reg == C_LAST));
    assign s_tready = !in_valid_reg || in_done;

    // Hold the record being worked on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            in_mode_reg  <= MODE_REC;
            snap_idx_reg <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (s_tvalid && s_tready)
                in_mode_reg <= s_tuser;
            if (in_done)
                snap_idx_reg <= '0;
            else if (out_load)
                snap_idx_reg <= snap_idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_rec_reg <= s_rec;
    end

    brsc_update #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_update (
        .enable   (in_valid_reg),
        .mode     (in_mode_reg),
        .rec      (in_rec_reg),
        .seq_cur  (seq_reg),
        .cnt_cur  (counters_reg),
        .seq_next (seq_next),
        .cnt_next (counters_next)
    );

    // Advance the counters and sequence tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COUNTERS; i++)
                counters_reg[i] <= '0;
            seq_reg <= '0;
        end
        else
        begin
            counters_reg <= counters_next;
            seq_reg      <= seq_next;
        end
    end

    // Output register for counter words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_data_reg <= M_TDATA_W'(counters_reg[snap_idx_reg]);
            m_idx_reg  <= snap_idx_reg;
            m_last_reg <= (snap_idx_reg == C_LAST);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_idx_reg;
    assign m_tlast  = m_last_reg;

    // Checks
    `BRSC_ASSERT_NOW(a_last_idx, m_tvalid && m_tlast, m_tuser == C_LAST)
    `BRSC_ASSERT_NOW(a_walk_in_snap, snap_idx_reg != 4'd0, is_snap)
    `BRSC_ASSERT_NOW(a_stall_only_snap, !s_tready, is_snap)
    `BRSC_ASSERT_NEXT(a_req_monotonic, in_valid_reg,
        counters_reg[C_REQ] >= $past(counters_reg[C_REQ]))

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for block_read_statistics_counters: random and directed read records,
// with the counter words of each snapshot checked against an in-bench tally of all counters.
// Depends on brsc_pkg and the block itself; nothing else.
module tb;
    import brsc_pkg::*;

    localparam int               CW          = COUNTER_WIDTH_DEF;
    localparam logic [63:0]      TALLY_MAX   = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - CW);
    localparam logic [63:0]      ALL64       = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int               HOLD_CYCLES = 200;
    localparam int               CYCLE_LIMIT = 200000;
    localparam int               DRAIN_WAIT  = 20;

    // One input word: mode plus the read record
    typedef struct {
        logic [MODE_W-1:0] mode;
        rec_t              rec;
    } read_word_t;

    // One output word of a snapshot
    typedef struct {
        logic [CIDX_W-1:0] index;
        logic [63:0]       value;
        logic              last;
    } counter_word_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [MODE_W-1:0]    s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [CIDX_W-1:0]    m_tuser;
    logic                 m_tlast;

    // Stimulus and expectations
    read_word_t    read_q[$];
    counter_word_t counter_q[$];
    counter_word_t want_word;
    logic [63:0]   gen_seq_end = '0;
    bit            took_word   = 1'b0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            hold_requests = 0;

    // Predicted block state
    logic [63:0] tally [NUM_COUNTERS] = '{default: '0};
    logic [63:0] seq_end_model  = '0;
    logic        seq_seen_model = 1'b0;

    // Run statistics
    int mismatches    = 0;
    int words_checked = 0;
    int n_records     = 0;
    int n_drive       = 0;
    int n_snapshots   = 0;
    int n_ignored     = 0;
    int n_seq_hits    = 0;
    int n_disc_hits   = 0;
    int cycles        = 0;

    block_read_statistics_counters #(
        .COUNTER_WIDTH (CW)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Saturating add at the counter width
    function automatic logic [63:0] sat_add(input logic [63:0] cur, input logic [63:0] amount);
        logic [63:0] base;
        base = (cur > TALLY_MAX) ? TALLY_MAX : cur;
        return (amount > TALLY_MAX - base) ? TALLY_MAX : base + amount;
    endfunction

    // Lay the record out on tdata, offset in the lowest bits
    function automatic logic [S_TDATA_W-1:0] pack_record(input rec_t r);
        return {6'd0, r.service_ms, r.after_bytes, r.after_sectors, r.after_commands,
                r.before_bytes, r.before_sectors, r.before_commands,
                r.succeeded, r.seq_track, r.length, r.offset};
    endfunction

    // Update the predicted counters for one accepted word; queue snapshot words
    task automatic account_read(input read_word_t w);
        logic [63:0] len;
        logic [63:0] peak;
        logic [63:0] cmd_delta;
        int          i;
        len = {32'd0, w.rec.length};
        case (w.mode)
            MODE_SNAP:
            begin
                n_snapshots++;
                for (i = 0; i < NUM_COUNTERS; i++)
                    counter_q.push_back('{index: i[CIDX_W-1:0], value: tally[i],
                                          last: (i == C_LAST)});
            end
            MODE_REC, MODE_REC_DRV:
            begin
                n_records++;
                tally[C_REQ]       = sat_add(tally[C_REQ], 64'd1);
                tally[C_REQ_BYTES] = sat_add(tally[C_REQ_BYTES], len);
                tally[C_SVC_MS]    = sat_add(tally[C_SVC_MS], w.rec.service_ms);
                peak = (w.rec.service_ms > TALLY_MAX) ? TALLY_MAX : w.rec.service_ms;
                if (peak > tally[C_PEAK_MS])
                    tally[C_PEAK_MS] = peak;
                // First sequenced read only arms the tracking
                if (w.rec.seq_track)
                begin
                    if (seq_seen_model)
                    begin
                        if (w.rec.offset == seq_end_model)
                        begin
                            tally[C_SEQ] = sat_add(tally[C_SEQ], 64'd1);
                            n_seq_hits++;
                        end
                        else
                        begin
                            tally[C_DISC] = sat_add(tally[C_DISC], 64'd1);
                            n_disc_hits++;
                        end
                    end
                    seq_end_model  = w.rec.offset + len;
                    seq_seen_model = 1'b1;
                end
                if (w.rec.succeeded)
                begin
                    tally[C_OK]       = sat_add(tally[C_OK], 64'd1);
                    tally[C_OK_BYTES] = sat_add(tally[C_OK_BYTES], len);
                end
                else
                    tally[C_FAIL] = sat_add(tally[C_FAIL], 64'd1);
                // Drive totals count only when none of them went backwards
                if (w.mode == MODE_REC_DRV
                    && w.rec.after_commands >= w.rec.before_commands
                    && w.rec.after_sectors >= w.rec.before_sectors
                    && w.rec.after_bytes >= w.rec.before_bytes)
                begin
                    n_drive++;
                    cmd_delta = w.rec.after_commands - w.rec.before_commands;
                    tally[C_DRV_CMD]   = sat_add(tally[C_DRV_CMD], cmd_delta);
                    tally[C_DRV_SEC]   = sat_add(tally[C_DRV_SEC],
                                                 w.rec.after_sectors - w.rec.before_sectors);
                    tally[C_DRV_BYTES] = sat_add(tally[C_DRV_BYTES],
                                                 w.rec.after_bytes - w.rec.before_bytes);
                    if (cmd_delta != 0)
                        tally[C_WITH_IO] = sat_add(tally[C_WITH_IO], 64'd1);
                    else if (w.rec.succeeded)
                    begin
                        tally[C_NO_IO_REQ]   = sat_add(tally[C_NO_IO_REQ], 64'd1);
                        tally[C_NO_IO_BYTES] = sat_add(tally[C_NO_IO_BYTES], len);
                    end
                end
            end
            default:
                n_ignored++;
        endcase
    endtask

    // Queue one word for the driver; track the sequence end for the generator
    task automatic queue_read(input logic [MODE_W-1:0] mode, input logic [63:0] offset,
                              input logic [31:0] length, input logic seq, input logic ok,
                              input logic [63:0] bcmd, input logic [63:0] bsec,
                              input logic [63:0] bbyt, input logic [63:0] acmd,
                              input logic [63:0] asec, input logic [63:0] abyt,
                              input logic [63:0] elapsed);
        read_word_t w;
        w.mode                = mode;
        w.rec.offset          = offset;
        w.rec.length          = length;
        w.rec.seq_track       = seq;
        w.rec.succeeded       = ok;
        w.rec.before_commands = bcmd;
        w.rec.before_sectors  = bsec;
        w.rec.before_bytes    = bbyt;
        w.rec.after_commands  = acmd;
        w.rec.after_sectors   = asec;
        w.rec.after_bytes     = abyt;
        w.rec.service_ms      = elapsed;
        read_q.push_back(w);
        if ((mode == MODE_REC || mode == MODE_REC_DRV) && seq)
            gen_seq_end = offset + {32'd0, length};
    endtask

    task automatic queue_snapshot();
        queue_read(MODE_SNAP, '0, '0, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0, '0);
    endtask

    // Random records: half continuing the sequence, small drive deltas, a few backwards
    task automatic queue_random_reads(input int count);
        int                made;
        int                pick;
        logic [MODE_W-1:0] mode;
        logic [63:0]       offset;
        logic [31:0]       length;
        logic              seq;
        logic              ok;
        logic [63:0]       bcmd, bsec, bbyt, acmd, asec, abyt;
        made = 0;
        while (made < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
                mode = MODE_SNAP;
            else if (pick < 14)
                mode = MODE_UNUSED;
            else if (pick < 50)
                mode = MODE_REC;
            else
                mode = MODE_REC_DRV;
            seq = ($urandom_range(0, 99) < 80);
            case ($urandom_range(0, 5))
                0:       offset = rand64();
                1:       offset = {32'd0, $urandom_range(0, 4096)};
                2:       offset = gen_seq_end + 64'd1;
                default: offset = gen_seq_end;
            endcase
            length = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 65536);
            ok     = ($urandom_range(0, 99) < 85);
            bcmd   = rand64();
            bsec   = rand64();
            bbyt   = rand64();
            acmd   = ($urandom_range(0, 99) < 30) ? bcmd
                   : bcmd + {32'd0, $urandom_range(1, 64)};
            asec   = bsec + {32'd0, $urandom_range(0, 512)};
            abyt   = bbyt + {32'd0, $urandom_range(0, 262144)};
            case ($urandom_range(0, 19))
                0:       acmd = bcmd - {32'd0, $urandom_range(1, 100)};
                1:       asec = bsec - {32'd0, $urandom_range(1, 100)};
                2:       abyt = bbyt - {32'd0, $urandom_range(1, 100)};
                default: ;
            endcase
            queue_read(mode, offset, length, seq, ok, bcmd, bsec, bbyt, acmd, asec, abyt,
                       {32'd0, $urandom_range(0, 5000)});
            if (mode != MODE_UNUSED)
                made++;
        end
    endtask

    task automatic wait_drained();
        while (read_q.size() != 0 || counter_q.size() != 0)
            @(posedge clk);
    endtask

    // Input side: take the accepted word and predict
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            account_read(read_q.pop_front());
            took_word = 1'b1;
        end
    end

    // Input driver: hold the word until taken, then offer the next or idle
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || took_word))
        begin
            if (read_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tuser  <= read_q[0].mode;
                s_tdata  <= pack_record(read_q[0].rec);
            end
            else
                s_tvalid <= 1'b0;
        end
        took_word = 1'b0;
    end

    // Output ready: random stalls, plus a long hold-off when requested
    always @(negedge clk)
    begin : recv_ready
        int hold_served;
        int hold_left;
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Output monitor: compare each counter word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (counter_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected counter word: index %0d value %h last %b",
                             m_tuser, m_tdata, m_tlast);
            end
            else
            begin
                want_word = counter_q.pop_front();
                words_checked++;
                if (m_tuser !== want_word.index || m_tdata !== want_word.value
                    || m_tlast !== want_word.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("counter word mismatch: expected idx %0d val %h last %b, %s",
                                 want_word.index, want_word.value, want_word.last,
                                 $sformatf("got idx %0d val %h last %b",
                                           m_tuser, m_tdata, m_tlast));
                end
            end
        end
    end

    // Stop a hung run
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Phase 1: sender idles a third of the time, receiver more than half
        send_idle_pct = 34;
        recv_idle_pct = 61;

        // Directed: reset snapshot, sequence tracking, drive classes and extremes
        queue_snapshot();
        queue_read(MODE_REC, 64'd0, 32'd0, 1'b1, 1'b1, '0, '0, '0, '0, '0, '0, 64'd0);
        queue_read(MODE_REC, 64'd0, 32'h1000, 1'b1, 1'b1, '0, '0, '0, '0, '0, '0, 64'd7);
        queue_read(MODE_REC_DRV, 64'h1000, 32'hFFFF_FFFF, 1'b1, 1'b1,
                   64'd100, 64'd1000, 64'd4096, 64'd103, 64'd1008, 64'd8192, 64'd250);
        // Failed read, no drive I/O: neither drive class moves
        queue_read(MODE_REC_DRV, 64'd0, 32'd512, 1'b1, 1'b0,
                   ALL64, ALL64, ALL64, ALL64, ALL64, ALL64, 64'd1);
        // Successful read with no drive I/O
        queue_read(MODE_REC_DRV, 64'd77, 32'd4096, 1'b0, 1'b1,
                   '0, '0, '0, '0, '0, '0, 64'd3);
        // Each drive total going backwards on its own
        queue_read(MODE_REC_DRV, 64'd5, 32'd64, 1'b0, 1'b1,
                   64'd50, 64'd10, 64'd10, 64'd49, 64'd20, 64'd20, 64'd4);
        queue_read(MODE_REC_DRV, 64'd5, 32'd64, 1'b0, 1'b1,
                   64'd50, 64'd10, 64'd10, 64'd60, 64'd9, 64'd20, 64'd4);
        queue_read(MODE_REC_DRV, 64'd5, 32'd64, 1'b0, 1'b1,
                   64'd50, 64'd10, 64'd10, 64'd60, 64'd20, 64'd9, 64'd4);
        // Record without drive stats ignores the drive fields
        queue_read(MODE_REC, ALL64, 32'hFFFF_FFFF, 1'b0, 1'b0,
                   64'd1, 64'd1, 64'd1, 64'd900, 64'd900, 64'd900, 64'd9);
        // Sequence end wraps past the top of the offset range
        queue_read(MODE_REC, ALL64, 32'hFFFF_FFFF, 1'b1, 1'b1, '0, '0, '0, '0, '0, '0, 64'd2);
        queue_read(MODE_REC_DRV, 64'hFFFF_FFFE, 32'd0, 1'b1, 1'b1,
                   64'd8, 64'd8, 64'd8, 64'd9, 64'd9, 64'd9, 64'd9000);
        // Unused mode must leave the sequence state alone
        queue_read(MODE_UNUSED, rand64(), $urandom, 1'b1, 1'b1,
                   rand64(), rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
        queue_read(MODE_REC, 64'hFFFF_FFFE, 32'd16, 1'b1, 1'b0, '0, '0, '0, '0, '0, '0, 64'd20);
        queue_snapshot();

        queue_random_reads(60);
        queue_snapshot();
        wait_drained();

        // Phase 2: roles swapped
        send_idle_pct = 61;
        recv_idle_pct = 34;
        queue_random_reads(60);
        queue_snapshot();
        wait_drained();

        // Phase 3: no idling; hold the output off while snapshots pile up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests++;
        queue_snapshot();
        queue_snapshot();
        queue_snapshot();
        queue_random_reads(50);

        // Saturate service time, peak and drive totals, then confirm they stick
        queue_read(MODE_REC_DRV, rand64(), $urandom, 1'b1, 1'b1,
                   '0, '0, '0, ALL64, ALL64, ALL64, ALL64);
        queue_snapshot();
        queue_read(MODE_REC_DRV, rand64(), $urandom, 1'b1, 1'b1,
                   '0, '0, '0, ALL64, ALL64, ALL64, ALL64);
        queue_snapshot();
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("covered %0d records (%0d counting drive stats), %0d snapshots, %0d ignored",
                 n_records, n_drive, n_snapshots, n_ignored);
        $display("checked %0d counter words; %0d sequential and %0d discontinuous reads",
                 words_checked, n_seq_hits, n_disc_hits);
        if (counter_q.size() != 0)
            $display("%0d counter words never arrived", counter_q.size());
        if (mismatches == 0 && counter_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+design
design/brsc_pkg.sv
design/brsc_update.sv
design/block_read_statistics_counters.sv
sim/tb.sv
